/* rtl/core/mrrs_pkg.sv */
// ----------------------------------------------------------------------------
// mrrs_pkg: shared types and constants for the relay slave core
// Function codes, register pages, reset values, FSM state and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mrrs_pkg;

    localparam int NUM_POINTS_DEF = 16;
    localparam int FRAME_BYTES    = 8;
    localparam int CNT_W          = 3;
    localparam int MSG_BYTES      = 6;
    localparam int IDX_W          = 3;

    localparam logic [CNT_W-1:0] POS_FN     = 3'd1;
    localparam logic [CNT_W-1:0] POS_ADDR_H = 3'd2;
    localparam logic [CNT_W-1:0] POS_ADDR_L = 3'd3;
    localparam logic [CNT_W-1:0] POS_VAL_H  = 3'd4;
    localparam logic [CNT_W-1:0] POS_VAL_L  = 3'd5;
    localparam logic [CNT_W-1:0] POS_LAST   = CNT_W'(FRAME_BYTES - 1);

    localparam logic [7:0] FN_READ_COILS  = 8'h01;
    localparam logic [7:0] FN_READ_INPUTS = 8'h02;
    localparam logic [7:0] FN_READ_REG    = 8'h03;
    localparam logic [7:0] FN_WRITE_COIL  = 8'h05;
    localparam logic [7:0] FN_WRITE_REG   = 8'h06;

    localparam logic [7:0] PAGE_BAUD    = 8'h20;
    localparam logic [7:0] PAGE_ID      = 8'h40;
    localparam logic [7:0] PAGE_VERSION = 8'h80;
    localparam logic [7:0] REG_BYTES    = 8'h02;

    localparam logic [7:0]  FW_VERSION_RST = 8'd200;
    localparam logic [7:0]  DEVICE_ID_RST  = 8'd1;
    localparam logic [2:0]  BAUD_RST       = 3'd1;
    localparam logic [15:0] BAUD_MAX       = 16'd7;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic             capture;
        logic [CNT_W-1:0] pos;
        logic             decode;
        logic             load;
    } cmd_t;

    typedef struct packed {
        logic reply;
        logic out_free;
        logic final_byte;
    } status_t;

    // CRC-16/MODBUS, one byte, reflected
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/core/mrrs_ctrl.sv */
// ----------------------------------------------------------------------------
// mrrs_ctrl: frame sequencer
// Counts request bytes, triggers decode on the final byte and paces reply
// bytes into the output register.
// ----------------------------------------------------------------------------
module mrrs_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  mrrs_pkg::status_t status,
    output mrrs_pkg::cmd_t   cmd
);
    import mrrs_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic             accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            byte_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            byte_cnt_reg <= byte_cnt_next;
        end
    end

    always_comb begin
        byte_cnt_next = byte_cnt_reg;
        if (accept) begin
            byte_cnt_next = (byte_cnt_reg == POS_LAST) ? '0 : byte_cnt_reg + 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && byte_cnt_reg == POS_LAST) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                state_next = status.reply ? ST_SEND : ST_IDLE;
            end
            ST_SEND: begin
                if (status.out_free && status.final_byte) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.capture = accept;
        cmd.pos     = byte_cnt_reg;
        cmd.decode  = (state_reg == ST_DECODE);
        cmd.load    = (state_reg == ST_SEND) && status.out_free;
    end

endmodule

/* rtl/core/mrrs_datapath.sv */
// ----------------------------------------------------------------------------
// mrrs_datapath: request fields, slave state, reply builder and CRC
// Holds the request fields, coils, relays, id and baud index, builds the reply
// on decode and streams it through a running CRC into the output register.
// ----------------------------------------------------------------------------
module mrrs_datapath #(
    parameter int NUM_POINTS = mrrs_pkg::NUM_POINTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mrrs_pkg::cmd_t    cmd,
    output mrrs_pkg::status_t status,
    input  logic [7:0]        rx_byte,
    input  logic [15:0]       input_pins,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [7:0]        cfg_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        tx_byte,
    output logic              last_byte,
    output logic [15:0]       relay_drive,
    output logic [2:0]        baud_index
);
    import mrrs_pkg::*;

    localparam logic [15:0] NP = 16'(NUM_POINTS);

    logic [7:0]       fn_reg;
    logic [15:0]      addr_reg, val_reg, pins_reg;
    logic [15:0]      coil_reg, relay_reg;
    logic [7:0]       id_reg, fw_reg;
    logic [2:0]       baud_reg;
    logic [7:0]       msg_reg [MSG_BYTES];
    logic [IDX_W-1:0] len_reg, idx_reg;
    logic [15:0]      crc_reg;
    logic             m_tvalid_reg;
    logic [7:0]       tx_reg;
    logic             last_reg;
    logic [15:0]      relay_out_reg;
    logic [2:0]       baud_out_reg;

    logic [4:0]       n_sat;
    logic [15:0]      pt_bits;
    logic [7:0]       cnt_bytes;
    logic [7:0]       dec_msg [MSG_BYTES];
    logic [IDX_W-1:0] dec_len;
    logic             dec_reply;
    logic             in_map;
    logic             final_byte;
    logic [7:0]       cur_msg;
    logic [7:0]       tx_sel;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            unique case (cmd.pos)
                POS_FN:     fn_reg          <= rx_byte;
                POS_ADDR_H: addr_reg[15:8]  <= rx_byte;
                POS_ADDR_L: addr_reg[7:0]   <= rx_byte;
                POS_VAL_H:  val_reg[15:8]   <= rx_byte;
                POS_VAL_L:  val_reg[7:0]    <= rx_byte;
                POS_LAST:   pins_reg        <= input_pins;
                default: ;
            endcase
        end
    end

    // bit read window
    always_comb begin
        logic [15:0] p;
        n_sat = (val_reg < NP) ? val_reg[4:0] : 5'(NUM_POINTS);
        for (int i = 0; i < 16; i++) begin
            p = addr_reg + 16'(i);
            if (5'(i) >= n_sat) begin
                pt_bits[i] = 1'b0;
            end else if (p < NP) begin
                pt_bits[i] = (fn_reg == FN_READ_COILS) ? coil_reg[p[3:0]] : pins_reg[p[3:0]];
            end else begin
                pt_bits[i] = (fn_reg != FN_READ_COILS);
            end
        end
        cnt_bytes = 8'((6'(n_sat) + 6'd7) >> 3);
    end

    always_comb begin
        for (int k = 0; k < MSG_BYTES; k++) dec_msg[k] = 8'h00;
        dec_len   = '0;
        dec_reply = 1'b1;
        dec_msg[0] = id_reg;
        dec_msg[1] = fn_reg;
        unique case (fn_reg)
            FN_READ_COILS, FN_READ_INPUTS: begin
                dec_msg[2] = cnt_bytes;
                dec_msg[3] = pt_bits[7:0];
                dec_msg[4] = pt_bits[15:8];
                dec_len    = IDX_W'(3) + cnt_bytes[IDX_W-1:0];
            end
            FN_WRITE_COIL, FN_WRITE_REG: begin
                dec_msg[2] = addr_reg[15:8];
                dec_msg[3] = addr_reg[7:0];
                dec_msg[4] = val_reg[15:8];
                dec_msg[5] = val_reg[7:0];
                dec_len    = IDX_W'(6);
            end
            FN_READ_REG: begin
                dec_msg[2] = REG_BYTES;
                if (addr_reg[15:8] == PAGE_VERSION) begin
                    dec_msg[4] = fw_reg;
                end else if (addr_reg[15:8] == PAGE_ID) begin
                    dec_msg[3] = val_reg[15:8];
                    dec_msg[4] = val_reg[7:0];
                end
                dec_len = IDX_W'(5);
            end
            default: dec_reply = 1'b0;
        endcase
    end

    assign in_map = (addr_reg < NP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coil_reg  <= '0;
            relay_reg <= '0;
            id_reg    <= DEVICE_ID_RST;
            baud_reg  <= BAUD_RST;
            fw_reg    <= FW_VERSION_RST;
        end else begin
            if (cfg_valid && cfg_ready) fw_reg <= cfg_data;
            if (cmd.decode) begin
                if (fn_reg == FN_WRITE_COIL && in_map) begin
                    coil_reg[addr_reg[3:0]]  <= |val_reg[15:8];
                    relay_reg[addr_reg[3:0]] <= val_reg[8];
                end
                if (fn_reg == FN_WRITE_REG) begin
                    if (addr_reg[15:8] == PAGE_BAUD) begin
                        if (val_reg <= BAUD_MAX) baud_reg <= val_reg[2:0];
                    end else if (addr_reg[15:8] == PAGE_ID) begin
                        id_reg <= val_reg[7:0];
                    end
                end
            end
        end
    end

    assign final_byte = (idx_reg == len_reg + 1'b1);
    assign cur_msg    = msg_reg[idx_reg];

    always_comb begin
        if (idx_reg < len_reg) begin
            tx_sel = cur_msg;
        end else if (idx_reg == len_reg) begin
            tx_sel = crc_reg[7:0];
        end else begin
            tx_sel = crc_reg[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decode) begin
            for (int k = 0; k < MSG_BYTES; k++) msg_reg[k] <= dec_msg[k];
            len_reg <= dec_len;
            idx_reg <= '0;
            crc_reg <= CRC_INIT;
        end else if (cmd.load) begin
            idx_reg <= idx_reg + 1'b1;
            if (idx_reg < len_reg) crc_reg <= crc_byte(crc_reg, cur_msg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            tx_reg        <= tx_sel;
            last_reg      <= final_byte;
            relay_out_reg <= relay_reg;
            baud_out_reg  <= baud_reg;
        end
    end

    assign status.reply      = dec_reply;
    assign status.out_free   = !m_tvalid_reg || m_tready;
    assign status.final_byte = final_byte;

    assign m_tvalid    = m_tvalid_reg;
    assign tx_byte     = tx_reg;
    assign last_byte   = last_reg;
    assign relay_drive = relay_out_reg;
    assign baud_index  = baud_out_reg;

endmodule

/* rtl/core/modbus_rtu_relay_slave_core.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_relay_slave_core: Modbus RTU relay slave, 16 coils and inputs
// Fixed 8-byte request frames in, CRC-16/MODBUS terminated replies out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request byte per transfer together with the sampled
//   input pins; the pins of the eighth byte are the ones read.
//   m_* carries one reply byte per transfer; m_tlast marks the final byte.
//   Each reply byte also carries the relay levels and baud index in force
//   after the frame.
//   cfg_* writes the firmware version returned by read register 0x80xx.
// Timing:
//   Bytes 1..7 of a frame are taken while the sequencer is idle. The eighth
//   byte leads to the decode state, then reply bytes leave one per cycle
//   while m_tready allows (running CRC) for 0 to 8 bytes; the next request
//   byte is taken once the final reply byte sits in the output register.
// Reset: coils and relays clear, device id 1, baud index 1, version 200,
//   frame position returns to byte 0.
// A stalled m_tready holds the output register and pauses the reply.
// ----------------------------------------------------------------------------
module modbus_rtu_relay_slave_core #(
    parameter int NUM_POINTS = mrrs_pkg::NUM_POINTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // rx_byte[7:0], input_pins[23:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tx_byte[7:0], relay_drive[23:8], baud_index[26:24], 0
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import mrrs_pkg::*;

    cmd_t        cmd;
    status_t     status;
    logic [7:0]  tx_byte;
    logic [15:0] relay_drive;
    logic [2:0]  baud_index;

    assign cfg_ready = 1'b1;

    mrrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mrrs_datapath #(
        .NUM_POINTS (NUM_POINTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .rx_byte     (s_tdata[7:0]),
        .input_pins  (s_tdata[23:8]),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .tx_byte     (tx_byte),
        .last_byte   (m_tlast),
        .relay_drive (relay_drive),
        .baud_index  (baud_index)
    );

    assign m_tdata = {5'b00000, baud_index, relay_drive, tx_byte};

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for modbus_rtu_relay_slave_core
// Request frames are fed byte by byte on the s_ stream. A behavioral model
// of the slave predicts every reply byte, and each one is checked on the m_
// stream against its relay levels and baud index. Directed frames cover each
// function code and the off-map, saturation, wrap and ignore cases. Random
// frames follow under three sender/receiver stall mixes, with version
// register writes between the phases.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mrrs_pkg::*;

    localparam int POINTS    = NUM_POINTS_DEF;
    localparam int MAX_CYCLE = 200000;
    localparam int DRAIN     = 20;

    typedef struct {
        logic [7:0]  tx;
        logic        last;
        logic [15:0] relay;
        logic [2:0]  baud;
    } reply_byte_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // rx_byte[7:0], input_pins[23:8]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // tx_byte[7:0], relay_drive[23:8], baud_index[26:24], 0
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    // slave model state
    logic [7:0]  mdl_frame [0:6];
    logic [2:0]  mdl_count;
    logic [15:0] mdl_coils;
    logic [15:0] mdl_relays;
    logic [7:0]  mdl_dev_id;
    logic [2:0]  mdl_baud;
    logic [7:0]  mdl_version;

    reply_byte_t expected_reply [$];

    int errors         = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_left     = 0;
    int frames_sent    = 0;
    int bytes_sent     = 0;
    int replies_seen   = 0;
    int version_writes = 0;

    modbus_rtu_relay_slave_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLE) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [15:0] modbus_crc16(input logic [7:0] msg [0:9], input int len);
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < len; i++) begin
            crc = crc ^ {8'h00, msg[i]};
            for (int b = 0; b < 8; b++) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

    task automatic model_reset();
        for (int k = 0; k < 7; k++) mdl_frame[k] = '0;
        mdl_count   = '0;
        mdl_coils   = '0;
        mdl_relays  = '0;
        mdl_dev_id  = DEVICE_ID_RST;
        mdl_baud    = BAUD_RST;
        mdl_version = FW_VERSION_RST;
    endtask

    // advance the slave model by one request byte, queue the reply it causes
    task automatic model_take_byte(input logic [7:0] rx, input logic [15:0] pins);
        logic [7:0]  msg [0:9];
        logic [7:0]  fn;
        logic [15:0] addr, val, crc, mask, p;
        logic        bitv;
        int          n, len;
        reply_byte_t r;
        if (mdl_count < POS_LAST) begin
            mdl_frame[mdl_count] = rx;
            mdl_count = mdl_count + 3'd1;
            return;
        end
        mdl_count = '0;
        fn   = mdl_frame[1];
        addr = {mdl_frame[2], mdl_frame[3]};
        val  = {mdl_frame[4], mdl_frame[5]};
        for (int k = 0; k < 10; k++) msg[k] = '0;
        len = 0;
        case (fn)
            FN_READ_COILS, FN_READ_INPUTS: begin
                n = (val < POINTS) ? int'(val) : POINTS;
                msg[0] = mdl_dev_id;
                msg[1] = fn;
                msg[2] = 8'((n + 7) / 8);
                for (int i = 0; i < n; i++) begin
                    p = addr + 16'(i);
                    if (fn == FN_READ_COILS) bitv = (p < POINTS) ? mdl_coils[p[3:0]] : 1'b0;
                    else                     bitv = (p < POINTS) ? pins[p[3:0]] : 1'b1;
                    if (bitv) msg[3 + i / 8][i % 8] = 1'b1;
                end
                len = 3 + int'(msg[2]);
            end
            FN_WRITE_COIL: begin
                if (addr < POINTS) begin
                    mask = 16'h0001 << addr[3:0];
                    if (val[15:8] != 8'h00) mdl_coils = mdl_coils | mask;
                    else                    mdl_coils = mdl_coils & ~mask;
                    if (val[8]) mdl_relays = mdl_relays | mask;
                    else        mdl_relays = mdl_relays & ~mask;
                end
                msg[0] = mdl_dev_id;
                msg[1] = fn;
                for (int k = 2; k < 6; k++) msg[k] = mdl_frame[k];
                len = 6;
            end
            FN_WRITE_REG: begin
                msg[0] = mdl_dev_id;
                msg[1] = fn;
                for (int k = 2; k < 6; k++) msg[k] = mdl_frame[k];
                if (addr[15:8] == PAGE_BAUD) begin
                    if (val <= BAUD_MAX) mdl_baud = val[2:0];
                end else if (addr[15:8] == PAGE_ID) begin
                    mdl_dev_id = val[7:0];
                end
                len = 6;
            end
            FN_READ_REG: begin
                msg[0] = mdl_dev_id;
                msg[1] = fn;
                msg[2] = REG_BYTES;
                if (addr[15:8] == PAGE_VERSION) begin
                    msg[4] = mdl_version;
                end else if (addr[15:8] == PAGE_ID) begin
                    msg[3] = val[15:8];
                    msg[4] = val[7:0];
                end
                len = 5;
            end
            default: len = 0;
        endcase
        if (len > 0) begin
            crc = modbus_crc16(msg, len);
            msg[len]     = crc[7:0];
            msg[len + 1] = crc[15:8];
            len = len + 2;
            for (int k = 0; k < len; k++) begin
                r.tx    = msg[k];
                r.last  = (k == len - 1);
                r.relay = mdl_relays;
                r.baud  = mdl_baud;
                expected_reply.push_back(r);
            end
        end
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] rx, input logic [15:0] pins);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pins, rx};
        do @(posedge aclk); while (!s_tready);
        model_take_byte(rx, pins);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_frame(input logic [7:0] fn, input logic [15:0] addr,
                              input logic [15:0] val, input logic [15:0] pins);
        logic [7:0] frame [0:7];
        frame[0] = 8'($urandom_range(255));
        frame[1] = fn;
        frame[2] = addr[15:8];
        frame[3] = addr[7:0];
        frame[4] = val[15:8];
        frame[5] = val[7:0];
        frame[6] = 8'($urandom_range(255));
        frame[7] = 8'($urandom_range(255));
        for (int k = 0; k < 7; k++) send_byte(frame[k], 16'($urandom));
        send_byte(frame[7], pins);
        frames_sent++;
    endtask

    // wait for all replies, then let the decode cycle of a silent frame pass
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_reply.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_version(input logic [7:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        mdl_version = v;
        version_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    endtask

    always @(posedge aclk) begin : check_reply
        reply_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            replies_seen++;
            if (expected_reply.size() == 0) begin
                errors++;
                $display("%0t: unexpected reply byte, expected none, actual tdata 0x%0h tlast %b",
                         $time, m_tdata, m_tlast);
            end else begin
                want = expected_reply.pop_front();
                if (m_tdata[7:0] !== want.tx)      flag_mismatch("tx_byte", want.tx, m_tdata[7:0]);
                if (m_tlast !== want.last)         flag_mismatch("last_byte", want.last, m_tlast);
                if (m_tdata[23:8] !== want.relay)  flag_mismatch("relay_drive", want.relay,
                                                                 m_tdata[23:8]);
                if (m_tdata[26:24] !== want.baud)  flag_mismatch("baud_index", want.baud,
                                                                 m_tdata[26:24]);
                if (m_tdata[31:27] !== 5'b0)       flag_mismatch("tdata pad", 0, m_tdata[31:27]);
            end
        end
    end

    task automatic test_power_on_defaults();
        send_frame(FN_READ_REG, {PAGE_VERSION, 8'h00}, 16'h0001, 16'h0000);
        wait_idle();
    endtask

    task automatic test_version_register();
        write_version(8'hFF);
        send_frame(FN_READ_REG, {PAGE_VERSION, 8'h12}, 16'hFFFF, 16'hA5A5);
        wait_idle();
    endtask

    task automatic test_write_coil();
        send_frame(FN_WRITE_COIL, 16'd0, 16'hFF00, 16'h0000);
        send_frame(FN_WRITE_COIL, 16'd15, 16'h0200, 16'h0000);   // coil on, relay off
        send_frame(FN_WRITE_COIL, 16'd16, 16'hFF00, 16'h0000);   // off the map
        wait_idle();
    endtask

    task automatic test_read_coils();
        send_frame(FN_READ_COILS, 16'd0, 16'hFFFF, 16'h0000);    // saturates
        send_frame(FN_READ_COILS, 16'hFFFE, 16'd5, 16'h0000);    // wraps through off-map
        wait_idle();
    endtask

    task automatic test_read_inputs();
        send_frame(FN_READ_INPUTS, 16'd10, 16'd9, 16'h0000);     // tail off the map
        send_frame(FN_READ_INPUTS, 16'd3, 16'd0, 16'hFFFF);      // zero quantity
        wait_idle();
    endtask

    task automatic test_write_register();
        send_frame(FN_WRITE_REG, {PAGE_BAUD, 8'h33}, 16'd8, 16'h0000);    // ignored
        send_frame(FN_WRITE_REG, {PAGE_ID, 8'h00}, 16'h12F7, 16'h0000);   // old id echoed
        wait_idle();
    endtask

    task automatic test_unknown_functions();
        send_frame(8'h10, 16'h0000, 16'h0002, 16'h0000);
        wait_idle();
    endtask

    task automatic test_output_stall();
        stall_left = 400;
        for (int k = 0; k < 2; k++) send_frame(FN_READ_COILS, 16'd0, 16'd16, 16'($urandom));
        wait_idle();
    endtask

    task automatic send_random_frame();
        int          pick;
        logic [7:0]  fn;
        logic [15:0] addr, val;
        pick = $urandom_range(99);
        if (pick < 12) begin
            for (int k = 0; k < 8; k++) send_byte(8'($urandom_range(255)), 16'($urandom));
            frames_sent++;
            return;
        end
        case ($urandom_range(3))
            0:       addr = 16'($urandom_range(POINTS - 1));
            1:       addr = 16'($urandom_range(POINTS + 4, POINTS - 4));
            2:       addr = 16'($urandom_range(16'hFFFF, 16'hFFF0));
            default: addr = 16'($urandom);
        endcase
        val = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20));
        if (pick < 20) begin
            fn = 8'($urandom_range(255));
        end else begin
            case ($urandom_range(4))
                0: fn = FN_READ_COILS;
                1: fn = FN_READ_INPUTS;
                2: fn = FN_READ_REG;
                3: fn = FN_WRITE_COIL;
                default: fn = FN_WRITE_REG;
            endcase
        end
        if (fn == FN_WRITE_COIL) begin
            case ($urandom_range(3))
                0: val[15:8] = 8'h00;
                1: val[15:8] = 8'hFF;
                2: val[15:8] = 8'h01;
                default: val[15:8] = 8'($urandom_range(255));
            endcase
        end
        if (fn == FN_READ_REG || fn == FN_WRITE_REG) begin
            case ($urandom_range(3))
                0: addr[15:8] = PAGE_BAUD;
                1: addr[15:8] = PAGE_ID;
                2: addr[15:8] = PAGE_VERSION;
                default: ;
            endcase
            if (addr[15:8] == PAGE_BAUD && $urandom_range(1)) val = 16'($urandom_range(9));
        end
        send_frame(fn, addr, val, 16'($urandom));
    endtask

    task automatic test_random_traffic(input int n_frames);
        for (int k = 0; k < n_frames; k++) send_random_frame();
        wait_idle();
    endtask

    initial begin
        model_reset();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 17;
        recv_idle_pct = 49;
        test_power_on_defaults();
        test_version_register();
        test_write_coil();
        test_read_coils();
        test_read_inputs();
        test_write_register();
        test_unknown_functions();
        test_output_stall();

        write_version(8'($urandom_range(255)));
        test_random_traffic(1);
        send_idle_pct = 49;
        recv_idle_pct = 17;
        write_version(8'($urandom_range(255)));
        test_random_traffic(1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_version(FW_VERSION_RST);
        test_random_traffic(1);

        if (expected_reply.size() != 0) begin
            errors++;
            $display("%0t: reply bytes missing, expected %0d more, actual 0",
                     $time, expected_reply.size());
        end
        $display("Sent %0d request frames (%0d bytes), checked %0d reply bytes, %0d version writes.",
                 frames_sent, bytes_sent, replies_seen, version_writes);
        $display("Covered all function codes, off-map points, wrap, saturation and stall mixes.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
